FILE: rtl/dcr_pkg.sv
// Shared constants, field layout and controller/datapath interface types for the reporter.
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

   // Field widths
   localparam int SLAVE_W    = 4;
   localparam int CHANNEL_W  = 5;
   localparam int VALUE_W    = 32;
   localparam int DEADBAND_W = 16;

   // Stream payload layout
   localparam int FIELDS_W = SLAVE_W + CHANNEL_W + VALUE_W;
   localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
   localparam int PAD_W    = TDATA_W - FIELDS_W;
   localparam int TUSER_W  = 2;

   localparam int SLAVE_LSB   = 0;
   localparam int CHANNEL_LSB = SLAVE_LSB + SLAVE_W;
   localparam int VALUE_LSB   = CHANNEL_LSB + CHANNEL_W;

   localparam int TUSER_REQ_BIT  = 0;
   localparam int TUSER_KIND_BIT = 1;

   // Request and channel codes
   localparam logic REQ_PRIME   = 1'b0;
   localparam logic KIND_ANALOG = 1'b1;

   // Defaults
   localparam int MAX_SLAVES_DEF   = 16;
   localparam int MAX_CHANNELS_DEF = 32;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd327;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // write zero at the sweep address, advance sweep
      logic accept;     // capture request, launch table read
      logic commit;     // write captured sample into the table
      logic out_load;   // load the result register
   } dcr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done; // sweep is at the last entry
      logic in_range;   // captured indexes address a table entry
      logic is_prime;   // captured request primes silently
      logic report_hit; // captured sample differs enough to report
      logic out_free;   // result register can take a value this cycle
   } dcr_status_type;

endpackage

`default_nettype wire

FILE: rtl/dcr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module dcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/dcr_ctrl.sv
// Sequencing state machine: table clearing sweep, request capture and evaluation.
`timescale 1ns / 1ps
`default_nettype none

module dcr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire dcr_pkg::dcr_status_type status,
   output dcr_pkg::dcr_cmd_type         cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       needs_out;

   // A report that must wait for the result register to drain
   assign needs_out = status.in_range && !status.is_prime && status.report_hit;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!status.in_range) begin
               state_in = ST_IDLE;
            end else if (status.is_prime) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (!status.report_hit) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.commit   = 1'b1;
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid) |=> (state_ff == ST_EVAL))
      else $error("accepted transfer not followed by evaluation");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (status.report_hit && status.out_free && cmd.commit))
      else $error("result loaded without room or without table update");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_done) |=> (state_ff == ST_IDLE))
      else $error("clearing sweep did not hand over to idle");

   a_eval_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && !(needs_out && !status.out_free)) |=> (state_ff == ST_IDLE))
      else $error("evaluation stalled without a blocked report");

endmodule

`default_nettype wire

FILE: rtl/dcr_datapath.sv
// Datapath: deadband register, last-value table, change compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module dcr_datapath #(
   parameter int MAX_SLAVES   = dcr_pkg::MAX_SLAVES_DEF,
   parameter int MAX_CHANNELS = dcr_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [dcr_pkg::TDATA_W-1:0]       req_tdata,
   input  wire logic [dcr_pkg::TUSER_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [dcr_pkg::TDATA_W-1:0]       rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [dcr_pkg::DEADBAND_W-1:0]    csr_wdata,
   input  wire dcr_pkg::dcr_cmd_type              cmd,
   output dcr_pkg::dcr_status_type                status
);

   localparam int DEPTH = MAX_SLAVES * MAX_CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Request fields
   logic [dcr_pkg::SLAVE_W-1:0]   req_slave;
   logic [dcr_pkg::CHANNEL_W-1:0] req_channel;
   logic [dcr_pkg::VALUE_W-1:0]   req_value;
   logic                          req_in_range;
   logic [AW-1:0]                 req_addr;

   // Captured request
   logic [dcr_pkg::SLAVE_W-1:0]   slave_ff;
   logic [dcr_pkg::CHANNEL_W-1:0] channel_ff;
   logic [dcr_pkg::VALUE_W-1:0]   value_ff;
   logic                          prime_ff;
   logic                          analog_ff;
   logic                          in_range_ff;
   logic [AW-1:0]                 addr_ff;

   logic [dcr_pkg::DEADBAND_W-1:0] deadband_ff;
   logic [AW-1:0]                  clr_addr_ff;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [dcr_pkg::VALUE_W-1:0]   ram_wdata;
   logic [dcr_pkg::VALUE_W-1:0]   stored;

   logic signed [dcr_pkg::VALUE_W:0] diff_fwd;
   logic signed [dcr_pkg::VALUE_W:0] diff_rev;
   logic        [dcr_pkg::VALUE_W:0] magnitude;
   logic                             changed;
   logic                             past_band;

   logic                          rsp_tvalid_ff;
   logic [dcr_pkg::SLAVE_W-1:0]   rsp_slave_ff;
   logic [dcr_pkg::CHANNEL_W-1:0] rsp_channel_ff;
   logic [dcr_pkg::VALUE_W-1:0]   rsp_value_ff;

   // Unpack request and form table address
   assign req_slave   = req_tdata[dcr_pkg::SLAVE_LSB +: dcr_pkg::SLAVE_W];
   assign req_channel = req_tdata[dcr_pkg::CHANNEL_LSB +: dcr_pkg::CHANNEL_W];
   assign req_value   = req_tdata[dcr_pkg::VALUE_LSB +: dcr_pkg::VALUE_W];
   assign req_in_range = (32'(req_slave) < 32'(MAX_SLAVES)) &&
                         (32'(req_channel) < 32'(MAX_CHANNELS));
   assign req_addr = AW'(32'(req_slave) * 32'(MAX_CHANNELS) + 32'(req_channel));

   // Capture request on transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slave_ff    <= req_slave;
         channel_ff  <= req_channel;
         value_ff    <= req_value;
         prime_ff    <= (req_tuser[dcr_pkg::TUSER_REQ_BIT] == dcr_pkg::REQ_PRIME);
         analog_ff   <= (req_tuser[dcr_pkg::TUSER_KIND_BIT] == dcr_pkg::KIND_ANALOG);
         in_range_ff <= req_in_range;
         addr_ff     <= req_addr;
      end
   end

   // Deadband register
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= dcr_pkg::DEADBAND_RESET;
      end else if (csr_we) begin
         deadband_ff <= csr_wdata;
      end
   end

   // Clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr && !status.clear_done) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // Table write: zero during the sweep, otherwise the captured sample
   assign ram_we    = cmd.clear_wr || cmd.commit;
   assign ram_waddr = cmd.clear_wr ? clr_addr_ff : addr_ff;
   assign ram_wdata = cmd.clear_wr ? '0 : value_ff;

   dcr_ram #(
      .WIDTH (dcr_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_addr),
      .rd_data (stored)
   );

   // Change and deadband compare at one extra bit so the difference cannot wrap
   assign diff_fwd  = $signed({value_ff[dcr_pkg::VALUE_W-1], value_ff}) -
                      $signed({stored[dcr_pkg::VALUE_W-1], stored});
   assign diff_rev  = $signed({stored[dcr_pkg::VALUE_W-1], stored}) -
                      $signed({value_ff[dcr_pkg::VALUE_W-1], value_ff});
   assign magnitude = diff_fwd[dcr_pkg::VALUE_W] ? diff_rev : diff_fwd;
   assign changed   = (value_ff != stored);
   assign past_band = (magnitude >= (dcr_pkg::VALUE_W + 1)'(deadband_ff));

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_slave_ff   <= slave_ff;
         rsp_channel_ff <= channel_ff;
         rsp_value_ff   <= value_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{dcr_pkg::PAD_W{1'b0}}, rsp_value_ff, rsp_channel_ff, rsp_slave_ff};

   // Status to the controller
   always_comb begin
      status            = '0;
      status.clear_done = (clr_addr_ff == AW'(DEPTH - 1));
      status.in_range   = in_range_ff;
      status.is_prime   = prime_ff;
      status.report_hit = changed && (!analog_ff || past_band);
      status.out_free   = !rsp_tvalid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

FILE: rtl/deadband_change_reporter_core.sv
// Top level of the deadband change reporter: controller plus datapath.
// A request is captured at its transfer and compared in the cycle after; a report then loads
// the register driving rsp_tvalid. No new request is taken before the last leaves evaluation,
// as the last-value table is read then updated. A report waits in the evaluation state while
// the result register is still full. Reset: synchronous; deadband returns to 327 and a sweep
// zeroes all MAX_SLAVES * MAX_CHANNELS entries (512 by default) with req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module deadband_change_reporter_core #(
   parameter int MAX_SLAVES   = dcr_pkg::MAX_SLAVES_DEF,
   parameter int MAX_CHANNELS = dcr_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: slave_index[3:0], channel_index[8:4], sample_value[40:9], zero pad [47:41]
   input  wire logic [dcr_pkg::TDATA_W-1:0]    req_tdata,
   // tuser: req_type[0], channel_kind[1]
   input  wire logic [dcr_pkg::TUSER_W-1:0]    req_tuser,
   // Report channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: report_slave[3:0], report_channel[8:4], report_value[40:9], zero pad [47:41]
   output logic      [dcr_pkg::TDATA_W-1:0]    rsp_tdata,
   // Deadband register write
   input  wire logic                           csr_we,
   input  wire logic [dcr_pkg::DEADBAND_W-1:0] csr_wdata
);

   dcr_pkg::dcr_cmd_type    cmd;
   dcr_pkg::dcr_status_type status;

   dcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcr_datapath #(
      .MAX_SLAVES   (MAX_SLAVES),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
